>>> hdl/controller_to_mouse_report_top_defines.svh
// ---------------------------------------------------------------------------
// Controller to mouse report: assertion macros
// Shared macros for the concurrent checks on the top-level ports.
// ---------------------------------------------------------------------------
`ifndef CONTROLLER_TO_MOUSE_REPORT_TOP_DEFINES_SVH
`define CONTROLLER_TO_MOUSE_REPORT_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define CTMR_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define CTMR_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/ctmr_pkg.sv
// ---------------------------------------------------------------------------
// Controller to mouse report: package
// Shared widths, register indexes and the structs passed between modules.
// ---------------------------------------------------------------------------
`default_nettype none

package ctmr_pkg;

    // Register indexes of the configuration port.
    localparam logic [1:0] REG_DEADZONE = 2'd0;
    localparam logic [1:0] REG_DIVISOR  = 2'd1;
    localparam logic [1:0] REG_CTYPE    = 2'd2;

    // Controller layouts.
    localparam logic CTYPE_NUNCHUK = 1'b0;
    localparam logic CTYPE_CLASSIC = 1'b1;

    // Fixed constants of the decoding.
    localparam logic [7:0] STICK_CENTRE = 8'h80;
    localparam logic [4:0] WHEEL_HIGH   = 5'd24;  // centre 16 plus threshold 8
    localparam logic [4:0] WHEEL_LOW    = 5'd8;   // centre 16 minus threshold 8
    localparam int         DIV_STEPS    = 8;
    localparam int         CNT_W        = $clog2(DIV_STEPS);

    // Wheel step codes.
    localparam logic [1:0] WHEEL_NONE = 2'b00;
    localparam logic [1:0] WHEEL_UP   = 2'b01;
    localparam logic [1:0] WHEEL_DOWN = 2'b11;

    // Decoded report fields.
    typedef struct packed {
        logic [7:0] stick_x;
        logic [7:0] stick_y;
        logic [4:0] axis;
        logic [7:0] buttons;
    } decode_t;

    // Request to the shared divider.
    typedef struct packed {
        logic       start;
        logic [7:0] dividend;
        logic [7:0] divisor;
    } div_req_t;

    // Status back from the shared divider.
    typedef struct packed {
        logic       busy;
        logic       done;
        logic [7:0] quotient;
    } div_rsp_t;

endpackage

`default_nettype wire

>>> hdl/ctmr_decode.sv
// ---------------------------------------------------------------------------
// Controller to mouse report: report decoder
// Maps the raw report bytes to stick, wheel axis and button fields.
// ---------------------------------------------------------------------------
`default_nettype none

module ctmr_decode
(
    input  wire logic             ctype,
    input  wire logic [7:0]       byte0,
    input  wire logic [7:0]       byte1,
    input  wire logic [7:0]       byte2,
    input  wire logic [7:0]       byte4,
    input  wire logic [7:0]       byte5,
    output ctmr_pkg::decode_t     dec
);

    // Layout selection; buttons are active low on the wire.
    always_comb
    begin
        dec = '0;
        if (ctype == ctmr_pkg::CTYPE_NUNCHUK)
        begin
            dec.stick_x    = byte0;
            dec.stick_y    = ~byte1;
            dec.axis       = 5'd0;
            dec.buttons[0] = ~byte5[0];
            dec.buttons[1] = ~byte5[1];
        end
        else
        begin
            dec.stick_x    = {byte0[5:0], 2'b00};
            dec.stick_y    = ~{byte1[5:0], 2'b00};
            dec.axis       = byte2[4:0];
            dec.buttons[0] = ~byte5[6] | ~byte5[4];
            dec.buttons[1] = ~byte5[5] | ~byte5[3];
            dec.buttons[2] = ~byte4[2];
            dec.buttons[4] = ~byte5[0];
            dec.buttons[5] = ~byte4[6];
            dec.buttons[6] = ~byte4[7];
            dec.buttons[7] = ~byte5[1];
        end
    end

endmodule

`default_nettype wire

>>> hdl/ctmr_divider.sv
// ---------------------------------------------------------------------------
// Controller to mouse report: serial divider
// Restoring 8-bit by 8-bit divider producing one quotient bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module ctmr_divider
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire ctmr_pkg::div_req_t req,
    output ctmr_pkg::div_rsp_t      rsp
);

    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [ctmr_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic [7:0]                 rem_reg, rem_next;
    logic [7:0]                 quo_reg, quo_next;
    logic [7:0]                 dvs_reg, dvs_next;
    logic [8:0]                 shifted;
    logic [9:0]                 diff;
    logic                       fits;

    // One restoring step: shift in the next dividend bit and try a subtract.
    assign shifted = {rem_reg, quo_reg[7]};
    assign diff    = {1'b0, shifted} - {2'b00, dvs_reg};
    assign fits    = ~diff[9];

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = 8'd0;
            quo_next  = req.dividend;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[7:0] : shifted[7:0];
            quo_next = {quo_reg[6:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == ctmr_pkg::CNT_W'(ctmr_pkg::DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

`default_nettype wire

>>> hdl/controller_to_mouse_report_top.sv
// ---------------------------------------------------------------------------
// Controller to mouse report: top level
// Turns a 6-byte controller report into a relative mouse report.
// ---------------------------------------------------------------------------
// Usage:
// The input channel (in_valid/in_ready) carries one report beat of six bytes
// and the origin capture flag. The output channel (out_valid/out_ready)
// carries one mouse report beat per input beat, in order.
// Configuration registers (deadzone, divisor, controller type) are to be written
// through cfg_we/cfg_index/cfg_data while the block is idle; the block does not enforce this.
// Flow: the X magnitude passes through the shared serial divider, the Y
// magnitude is then handed to the divider for a second pass, and the output
// register is loaded after the Y pass ends. The input is ready again only
// after the output load, so a new report is not accepted while one is in work.
// If the receiver stalls, the finished report waits in the output register
// and the next report is still accepted and divided; it then waits in the
// final stage until the output register frees up.
// Reset clears the configuration to deadzone 0, divisor 1, nunchuk layout,
// centres the origin and arms the one extra startup report.
// ---------------------------------------------------------------------------
`default_nettype none

module controller_to_mouse_report_top
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Configuration port
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_data,
    // Input channel
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  byte0,
    input  wire logic [7:0]  byte1,
    input  wire logic [7:0]  byte2,
    input  wire logic [7:0]  byte3,
    input  wire logic [7:0]  byte4,
    input  wire logic [7:0]  byte5,
    input  wire logic        first_after_init,
    // Output channel
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       buttons,
    output logic signed [7:0] dx,
    output logic signed [7:0] dy,
    output logic signed [1:0] wheel,
    output logic             report_changed
);

    typedef enum logic [3:0]
    {
        S_IDLE = 4'b0001,
        S_DIVX = 4'b0010,
        S_DIVY = 4'b0100,
        S_LOAD = 4'b1000
    } state_t;

    state_t             state_reg, state_next;

    // Configuration and persistent state.
    logic [6:0]         deadzone_reg;
    logic [7:0]         divisor_reg;
    logic               ctype_reg;
    logic [7:0]         origin_x_reg, origin_x_next;
    logic [7:0]         origin_y_reg, origin_y_next;
    logic               wheel_latched_reg, wheel_latched_next;
    logic [7:0]         sent_buttons_reg, sent_buttons_next;
    logic [1:0]         sent_wheel_reg, sent_wheel_next;
    logic               startup_reg, startup_next;

    // Per-report working registers.
    logic [7:0]         mag_y_reg;
    logic               neg_x_reg, neg_y_reg;
    logic [7:0]         qx_reg, qx_next;
    logic [7:0]         btn_reg;
    logic [1:0]         wcode_reg;
    logic               changed_reg;

    // Output register.
    logic               out_valid_reg, out_valid_next;
    logic [7:0]         buttons_reg;
    logic [7:0]         dx_reg, dy_reg;
    logic [1:0]         wheel_reg;
    logic               report_changed_reg;

    ctmr_pkg::decode_t  dec;
    ctmr_pkg::div_req_t div_req;
    ctmr_pkg::div_rsp_t div_rsp;

    logic               accept;
    logic               load_out;
    logic [7:0]         org_x, org_y;
    logic [8:0]         diff_x, diff_y;
    logic [7:0]         abs_x, abs_y;
    logic [7:0]         mag_x, mag_y;
    logic [1:0]         wcode;
    logic               wheel_hi, wheel_lo;
    logic               active, differs;
    logic signed [8:0]  x_val, y_val;
    logic [7:0]         x_out, y_out;
    logic               unused_byte3;

    // Byte 3 carries nothing that the decoding uses.
    assign unused_byte3 = ^byte3;

    ctmr_decode u_decode
    (
        .ctype (ctype_reg),
        .byte0 (byte0),
        .byte1 (byte1),
        .byte2 (byte2),
        .byte4 (byte4),
        .byte5 (byte5),
        .dec   (dec)
    );

    ctmr_divider u_divider
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid & in_ready;
    assign load_out = (state_reg == S_LOAD) & (~out_valid_reg | out_ready);

    // Stick offset from the origin; a capture makes the offset zero.
    assign org_x  = first_after_init ? dec.stick_x : origin_x_reg;
    assign org_y  = first_after_init ? dec.stick_y : origin_y_reg;
    assign diff_x = {1'b0, dec.stick_x} - {1'b0, org_x};
    assign diff_y = {1'b0, dec.stick_y} - {1'b0, org_y};
    assign abs_x  = diff_x[8] ? 8'(-diff_x) : diff_x[7:0];
    assign abs_y  = diff_y[8] ? 8'(-diff_y) : diff_y[7:0];

    // Deadzone removal on the magnitude.
    assign mag_x = (abs_x > {1'b0, deadzone_reg}) ? abs_x - {1'b0, deadzone_reg} : 8'd0;
    assign mag_y = (abs_y > {1'b0, deadzone_reg}) ? abs_y - {1'b0, deadzone_reg} : 8'd0;

    // Wheel axis threshold with a one-shot latch.
    assign wheel_hi = (dec.axis > ctmr_pkg::WHEEL_HIGH);
    assign wheel_lo = (dec.axis < ctmr_pkg::WHEEL_LOW);
    always_comb
    begin
        wcode = ctmr_pkg::WHEEL_NONE;
        if (wheel_hi && !wheel_latched_reg)
        begin
            wcode = ctmr_pkg::WHEEL_UP;
        end
        else if (wheel_lo && !wheel_latched_reg)
        begin
            wcode = ctmr_pkg::WHEEL_DOWN;
        end
    end

    // Change detection against the last sent report.
    assign active  = (mag_x != 8'd0) || (mag_y != 8'd0) || (wcode != ctmr_pkg::WHEEL_NONE)
                     || (dec.buttons[7:4] != 4'd0);
    assign differs = active || (dec.buttons != sent_buttons_reg) || (wcode != sent_wheel_reg);

    // State updates happen when the report beat is accepted.
    always_comb
    begin
        origin_x_next      = origin_x_reg;
        origin_y_next      = origin_y_reg;
        wheel_latched_next = wheel_latched_reg;
        sent_buttons_next  = sent_buttons_reg;
        sent_wheel_next    = sent_wheel_reg;
        startup_next       = startup_reg;
        if (accept)
        begin
            origin_x_next      = org_x;
            origin_y_next      = org_y;
            wheel_latched_next = wheel_hi | wheel_lo;
            startup_next       = startup_reg & differs;
            if (differs || startup_reg)
            begin
                sent_buttons_next = dec.buttons;
                sent_wheel_next   = wcode;
            end
        end
    end

    // Sequencer: X then Y through the shared divider, then output load.
    always_comb
    begin
        state_next       = state_reg;
        div_req.start    = 1'b0;
        div_req.dividend = mag_x;
        div_req.divisor  = (divisor_reg == 8'd0) ? 8'd1 : divisor_reg;
        qx_next          = qx_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    div_req.start = 1'b1;
                    state_next    = S_DIVX;
                end
            end
            S_DIVX:
            begin
                if (div_rsp.done)
                begin
                    qx_next          = div_rsp.quotient;
                    div_req.start    = 1'b1;
                    div_req.dividend = mag_y_reg;
                    state_next       = S_DIVY;
                end
            end
            S_DIVY:
            begin
                if (div_rsp.done)
                begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                if (load_out)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Sign restore, pad forcing and clamping of the quotients.
    always_comb
    begin
        x_val = neg_x_reg ? -$signed({1'b0, qx_reg}) : $signed({1'b0, qx_reg});
        y_val = neg_y_reg ? -$signed({1'b0, div_rsp.quotient})
                          : $signed({1'b0, div_rsp.quotient});
        if (btn_reg[4])
        begin
            y_val = -9'sd1;
        end
        if (btn_reg[5])
        begin
            y_val = 9'sd1;
        end
        if (btn_reg[6])
        begin
            x_val = 9'sd1;
        end
        if (btn_reg[7])
        begin
            x_val = -9'sd1;
        end
        if (x_val > 9'sd127)
        begin
            x_out = 8'sd127;
        end
        else if (x_val < -9'sd127)
        begin
            x_out = -8'sd127;
        end
        else
        begin
            x_out = x_val[7:0];
        end
        if (y_val > 9'sd127)
        begin
            y_out = 8'sd127;
        end
        else if (y_val < -9'sd127)
        begin
            y_out = -8'sd127;
        end
        else
        begin
            y_out = y_val[7:0];
        end
    end

    // Output register valid flag.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control and persistent state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            deadzone_reg      <= 7'd0;
            divisor_reg       <= 8'd1;
            ctype_reg         <= ctmr_pkg::CTYPE_NUNCHUK;
            origin_x_reg      <= ctmr_pkg::STICK_CENTRE;
            origin_y_reg      <= ctmr_pkg::STICK_CENTRE;
            wheel_latched_reg <= 1'b0;
            sent_buttons_reg  <= 8'd0;
            sent_wheel_reg    <= ctmr_pkg::WHEEL_NONE;
            startup_reg       <= 1'b1;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            origin_x_reg      <= origin_x_next;
            origin_y_reg      <= origin_y_next;
            wheel_latched_reg <= wheel_latched_next;
            sent_buttons_reg  <= sent_buttons_next;
            sent_wheel_reg    <= sent_wheel_next;
            startup_reg       <= startup_next;
            out_valid_reg     <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    ctmr_pkg::REG_DEADZONE: deadzone_reg <= cfg_data[6:0];
                    ctmr_pkg::REG_DIVISOR:  divisor_reg  <= cfg_data;
                    ctmr_pkg::REG_CTYPE:    ctype_reg    <= cfg_data[0];
                    default:                ;
                endcase
            end
        end
    end

    // Per-report payload registers.
    always_ff @(posedge clk)
    begin
        qx_reg <= qx_next;
        if (accept)
        begin
            mag_y_reg   <= mag_y;
            neg_x_reg   <= diff_x[8];
            neg_y_reg   <= diff_y[8];
            btn_reg     <= dec.buttons;
            wcode_reg   <= wcode;
            changed_reg <= differs | startup_reg;
        end
        if (load_out)
        begin
            buttons_reg        <= btn_reg;
            dx_reg             <= x_out;
            dy_reg             <= y_out;
            wheel_reg          <= wcode_reg;
            report_changed_reg <= changed_reg;
        end
    end

    // The Y quotient stays in the divider until the output is loaded.
    assign out_valid      = out_valid_reg;
    assign buttons        = buttons_reg;
    assign dx             = $signed(dx_reg);
    assign dy             = $signed(dy_reg);
    assign wheel          = $signed(wheel_reg ^ {2{unused_byte3 & 1'b0}});
    assign report_changed = report_changed_reg;

endmodule

`default_nettype wire

>>> hdl/ctmr_checker.sv
// ---------------------------------------------------------------------------
// Controller to mouse report: port checker
// Concurrent checks on the top-level ports, attached by bind.
// ---------------------------------------------------------------------------
`default_nettype none

`include "controller_to_mouse_report_top_defines.svh"

module ctmr_checker
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        in_ready,
    input  wire logic        out_valid,
    input  wire logic        out_ready,
    input  wire logic [7:0]  dx,
    input  wire logic [7:0]  dy,
    input  wire logic [1:0]  wheel,
    input  wire logic        report_changed
);

    // The block works on one report at a time.
    `CTMR_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready, "input accepted while a report is still in work")

    // A stalled result beat holds its motion fields.
    `CTMR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(dx) && $stable(dy) && $stable(wheel), "stalled output beat changed")

    // Motion is clamped to the symmetric range.
    `CTMR_ASSERT_NOW(a_clamp, clk, rst_n, out_valid, dx != 8'h80 && dy != 8'h80 && wheel != 2'b10, "motion or wheel outside its range")

    // An unchanged report carries no motion and no wheel step.
    `CTMR_ASSERT_NOW(a_quiet, clk, rst_n, out_valid && !report_changed, dx == 8'h00 && dy == 8'h00 && wheel == 2'b00, "motion in a report flagged unchanged")

endmodule

bind controller_to_mouse_report_top ctmr_checker u_ctmr_checker
(
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .dx             (dx),
    .dy             (dy),
    .wheel          (wheel),
    .report_changed (report_changed)
);

`default_nettype wire
